[sv/qbm_pkg.sv]
// Shared constants for the exhaustive QUBO minimizer.
`default_nettype none
package qbm_pkg;
  localparam int MAX_VARS    = 16;
  localparam int COEFF_WIDTH = 16;
  localparam int COEFF_IN_W  = 16;
  localparam int FIELD_W     = 4;
  localparam int VARS_W      = 5;
  localparam int ENERGY_W    = 24;
  localparam int VEC_W       = 16;
  localparam int VAR_W       = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int NUM_W       = $clog2(MAX_VARS + 1);
  localparam int DEPTH       = MAX_VARS * MAX_VARS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int ACC_W       = 2 * VAR_W + COEFF_WIDTH + 1;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int REG_IDX_W   = CFG_AW - 2;

  localparam logic [0:0]           ACT_LOAD  = 1'b0;
  localparam logic [0:0]           ACT_SOLVE = 1'b1;
  localparam logic [REG_IDX_W-1:0] REG_VARS  = '0;
  localparam logic [VARS_W-1:0]    VARS_RESET = VARS_W'(16);
endpackage
`default_nettype wire

[sv/qbm_if.sv]
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface qbm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic [qbm_pkg::FIELD_W-1:0]           row;
  logic [qbm_pkg::FIELD_W-1:0]           col;
  logic signed [qbm_pkg::COEFF_IN_W-1:0] coeff;
  modport source (output valid, action, row, col, coeff, input ready);
  modport sink (input valid, action, row, col, coeff, output ready);
endinterface

interface qbm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qbm_pkg::ENERGY_W-1:0] min_energy;
  logic [qbm_pkg::VEC_W-1:0]           best_vector;
  modport source (output valid, min_energy, best_vector, input ready);
  modport sink (input valid, min_energy, best_vector, output ready);
endinterface
`default_nettype wire

[sv/qubo_bruteforce_minimizer_core.sv]
// Top level: exhaustive QUBO search over a coefficient memory.
// Usage:
//   in_ch carries items. action=load writes coeff at (row, col) of the
//   matrix memory; loads stream back to back. action=solve scans all
//   2^n candidate vectors (n = vars_in_use, clamped to 16).
//   out_ch returns one item per solve: min_energy (at most 0) and
//   best_vector, the first minimizing vector (0 when nothing scores below 0).
//   The APB port holds vars_in_use at address 0; pready is always high.
// Solve:
//   Each candidate reads n*n coefficients through the single read port of
//   the matrix memory, one per cycle, then the drain state finishes the sum
//   and compare. in_ready is low while a solve runs.
// Reset (rst_n low, synchronous): control clears, vars_in_use returns to 16.
//   Matrix contents are not cleared; read only written entries.
// Stall: a result waits in the output register while out_ready is low;
//   loads are still taken, and a later solve holds its result until the
//   output register is free.
`default_nettype none
module qubo_bruteforce_minimizer_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  qbm_in_if.sink                            in_ch,
  qbm_out_if.source                         out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [qbm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [qbm_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [qbm_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import qbm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic signed [ACC_W-1:0] ENERGY_MIN_ACC = -(ACC_W'(1) <<< (ENERGY_W - 1));

  logic [1:0]                state_r, state_nxt;
  logic [VARS_W-1:0]         vars_r;
  logic [NUM_W-1:0]          n_r, n_nxt, n_eff;
  logic [MAX_VARS-1:0]       cand_r, cand_nxt, cand_last;
  logic [MAX_VARS:0]         span;
  logic [VAR_W-1:0]          ii_r, ii_nxt, jj_r, jj_nxt, last_idx;
  logic [MAX_VARS-1:0]       xvec;
  logic [NUM_W-1:0]          bit_idx [MAX_VARS];
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, sum, best_r, best_nxt;
  logic [MAX_VARS-1:0]       bits_r, bits_nxt;
  logic                      rd_vld_r, rd_inc_r, rd_last_r;
  logic [COEFF_WIDTH-1:0]    q_mem [DEPTH];
  logic [COEFF_WIDTH-1:0]    q_rdata_r;
  logic [ADDR_W-1:0]         wr_addr, rd_addr;
  logic                      in_fire, load_we, issue, out_free;
  logic                      out_valid_r;
  logic signed [ENERGY_W-1:0] out_energy_r;
  logic [VEC_W-1:0]          out_vector_r;
  logic                      cfg_we;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[CFG_AW-1:2] == REG_VARS);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_VARS) ?
                      CFG_DW'(vars_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vars_r <= VARS_RESET;
    end else if (cfg_we) begin
      vars_r <= cfg_pwdata[VARS_W-1:0];
    end
  end

  assign n_eff = (32'(vars_r) > MAX_VARS) ? NUM_W'(MAX_VARS) : NUM_W'(vars_r);

  // matrix memory
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign load_we = in_fire && (in_ch.action == ACT_LOAD) &&
                   (32'(in_ch.row) < MAX_VARS) && (32'(in_ch.col) < MAX_VARS);
  assign wr_addr = ADDR_W'(ADDR_W'(in_ch.row) * ADDR_W'(MAX_VARS) + ADDR_W'(in_ch.col));
  assign rd_addr = ADDR_W'(ADDR_W'(ii_r) * ADDR_W'(MAX_VARS) + ADDR_W'(jj_r));
  assign issue   = (state_r == S_SCAN);

  always_ff @(posedge clk) begin
    if (load_we) begin
      q_mem[wr_addr] <= COEFF_WIDTH'(in_ch.coeff);
    end
  end

  always_ff @(posedge clk) begin
    q_rdata_r <= q_mem[rd_addr];
  end

  // candidate bits in variable order: variable k is counter bit n-1-k
  always_comb begin
    for (int k = 0; k < MAX_VARS; k++) begin
      bit_idx[k] = n_r - NUM_W'(1) - NUM_W'(k);
      xvec[k] = (NUM_W'(k) < n_r) ? cand_r[bit_idx[k][VAR_W-1:0]] : 1'b0;
    end
  end

  assign span      = ({{MAX_VARS{1'b0}}, 1'b1} << n_r) - 1'b1;
  assign cand_last = span[MAX_VARS-1:0];
  assign last_idx  = VAR_W'(n_r - NUM_W'(1));
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    sum = acc_r + (rd_inc_r ?
          {{(ACC_W-COEFF_WIDTH){q_rdata_r[COEFF_WIDTH-1]}}, q_rdata_r} : '0);
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    cand_nxt  = cand_r;
    ii_nxt    = ii_r;
    jj_nxt    = jj_r;
    acc_nxt   = acc_r;
    best_nxt  = best_r;
    bits_nxt  = bits_r;
    if (rd_vld_r) begin
      acc_nxt = sum;
      if (rd_last_r) begin
        acc_nxt = '0;
        if (sum < best_r) begin
          best_nxt = sum;
          bits_nxt = xvec;
        end
      end
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.action == ACT_SOLVE)) begin
          n_nxt    = n_eff;
          cand_nxt = '0;
          ii_nxt   = '0;
          jj_nxt   = '0;
          acc_nxt  = '0;
          best_nxt = '0;
          bits_nxt = '0;
          state_nxt = (n_eff == '0) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (jj_r == last_idx) begin
          jj_nxt = '0;
          if (ii_r == last_idx) begin
            ii_nxt    = '0;
            state_nxt = S_DRAIN;
          end else begin
            ii_nxt = ii_r + 1'b1;
          end
        end else begin
          jj_nxt = jj_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (cand_r == cand_last) begin
          state_nxt = S_FIN;
        end else begin
          cand_nxt  = cand_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    cand_r    <= cand_nxt;
    ii_r      <= ii_nxt;
    jj_r      <= jj_nxt;
    acc_r     <= acc_nxt;
    best_r    <= best_nxt;
    bits_r    <= bits_nxt;
    rd_inc_r  <= xvec[ii_r] & xvec[jj_r];
    rd_last_r <= (ii_r == last_idx) && (jj_r == last_idx);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_energy_r <= (best_r < ENERGY_MIN_ACC) ? ENERGY_MIN_ACC[ENERGY_W-1:0] :
                      best_r[ENERGY_W-1:0];
      out_vector_r <= VEC_W'(bits_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.min_energy  = out_energy_r;
  assign out_ch.best_vector = out_vector_r;
endmodule
`default_nettype wire

[sv/qbm_checker.sv]
// Port-level checks for the QUBO minimizer, bound to the top level.
`default_nettype none
module qbm_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                in_action,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [qbm_pkg::ENERGY_W-1:0] out_min_energy,
  input wire logic [qbm_pkg::VEC_W-1:0]           out_best_vector
);
  import qbm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_min_energy) && $stable(out_best_vector))
    else $error("result item changed while stalled");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_SOLVE) |=> !in_ready)
    else $error("input taken during a solve");

  a_load_stream: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_LOAD) |=> in_ready)
    else $error("load item stalled the input");

  a_energy_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_energy[ENERGY_W-1] ||
                  ((out_min_energy == '0) && (out_best_vector == '0)))
    else $error("positive energy or nonzero vector at zero energy");
endmodule

bind qubo_bruteforce_minimizer_core qbm_checker u_qbm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_action       (in_ch.action),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_min_energy  (out_ch.min_energy),
  .out_best_vector (out_ch.best_vector)
);
`default_nettype wire
